// ===== hdl/btpm_pkg.sv =====
// ----------------------------------------------------------------------------
// Block-to-process mapper package
// Shared codes and fixed field widths of the block-to-process mapper.
// ----------------------------------------------------------------------------
package btpm_pkg;

   localparam int OP_W        = 3;
   localparam int RANK_IN_W   = 16;
   localparam int COORD_IN_W  = 16;
   localparam int BNUM_W      = 30;
   localparam int DIMREG_W    = 11;
   localparam int OWNER_W     = 17;
   localparam int LOCAL_W     = 31;
   localparam int LIN_W       = 32;
   localparam int COORD_OUT_W = 10;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [OP_W-1:0] OP_OWNER_COORD = 3'd0;
   localparam logic [OP_W-1:0] OP_OWNER_INDEX = 3'd1;
   localparam logic [OP_W-1:0] OP_LOCAL_COUNT = 3'd2;
   localparam logic [OP_W-1:0] OP_LOCAL_TO_GLOBAL = 3'd3;
   localparam logic [OP_W-1:0] OP_IS_LOCAL = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_BLOCKS_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCKS_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCKS_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_PROCESS = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PROCESS_TOTAL = 3'd4;

endpackage

// ===== hdl/btpm_div_cell.sv =====
// ----------------------------------------------------------------------------
// Divider cell
// One restoring division step on each lane, registered, with a side payload.
// ----------------------------------------------------------------------------
module btpm_div_cell import btpm_pkg::*; #(
   parameter int LANES = 1,
   parameter int W     = 16,
   parameter int DV    = 8,
   parameter int PLW   = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  logic [PLW-1:0]             in_pay,
   input  logic [LANES-1:0][W-1:0]    in_num,
   input  logic [LANES-1:0][DV-1:0]   in_div,
   input  logic [LANES-1:0][DV-1:0]   in_rem,
   output logic                       out_valid,
   output logic [PLW-1:0]             out_pay,
   output logic [LANES-1:0][W-1:0]    out_num,
   output logic [LANES-1:0][DV-1:0]   out_div,
   output logic [LANES-1:0][DV-1:0]   out_rem
);

   logic                     valid_ff;
   logic [PLW-1:0]           pay_ff;
   logic [LANES-1:0][W-1:0]  num_ff, num_in;
   logic [LANES-1:0][DV-1:0] div_ff;
   logic [LANES-1:0][DV-1:0] rem_ff, rem_in;
   logic [LANES-1:0][DV:0]   trial;
   logic [LANES-1:0]         fits;

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         trial[i]  = {in_rem[i], in_num[i][W-1]};
         fits[i]   = trial[i] >= {1'b0, in_div[i]};
         rem_in[i] = fits[i] ? DV'(trial[i] - {1'b0, in_div[i]}) : trial[i][DV-1:0];
         num_in[i] = {in_num[i][W-2:0], fits[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      pay_ff <= in_pay;
      num_ff <= num_in;
      div_ff <= in_div;
      rem_ff <= rem_in;
   end

   assign out_valid = valid_ff;
   assign out_pay   = pay_ff;
   assign out_num   = num_ff;
   assign out_div   = div_ff;
   assign out_rem   = rem_ff;

endmodule

// ===== hdl/btpm_div_chain.sv =====
// ----------------------------------------------------------------------------
// Divider chain
// A row of divider cells, one per quotient bit, taking one transaction a cycle.
// ----------------------------------------------------------------------------
module btpm_div_chain import btpm_pkg::*; #(
   parameter int LANES = 1,
   parameter int W     = 16,
   parameter int DV    = 8,
   parameter int PLW   = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  logic [PLW-1:0]             in_pay,
   input  logic [LANES-1:0][W-1:0]    in_num,
   input  logic [LANES-1:0][DV-1:0]   in_div,
   output logic                       out_valid,
   output logic [PLW-1:0]             out_pay,
   output logic [LANES-1:0][W-1:0]    out_quo,
   output logic [LANES-1:0][DV-1:0]   out_rem
);

   logic                     v_w   [W+1];
   logic [PLW-1:0]           pay_w [W+1];
   logic [LANES-1:0][W-1:0]  num_w [W+1];
   logic [LANES-1:0][DV-1:0] div_w [W+1];
   logic [LANES-1:0][DV-1:0] rem_w [W+1];

   assign v_w[0]   = in_valid;
   assign pay_w[0] = in_pay;
   assign num_w[0] = in_num;
   assign div_w[0] = in_div;
   assign rem_w[0] = '0;

   for (genvar i = 0; i < W; i++) begin : g_cell
      btpm_div_cell #(
         .LANES(LANES),
         .W    (W),
         .DV   (DV),
         .PLW  (PLW)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .in_valid (v_w[i]),
         .in_pay   (pay_w[i]),
         .in_num   (num_w[i]),
         .in_div   (div_w[i]),
         .in_rem   (rem_w[i]),
         .out_valid(v_w[i+1]),
         .out_pay  (pay_w[i+1]),
         .out_num  (num_w[i+1]),
         .out_div  (div_w[i+1]),
         .out_rem  (rem_w[i+1])
      );
   end

   assign out_valid = v_w[W];
   assign out_pay   = pay_w[W];
   assign out_quo   = num_w[W];
   assign out_rem   = rem_w[W];

endmodule

// ===== hdl/block_to_process_mapper.sv =====
// ----------------------------------------------------------------------------
// Block-to-process mapper
// Maps a 3-D block grid proportionally onto a contiguous range of processes.
//
//   channel  | handshake              | payload
//   ---------+------------------------+--------------------------------------
//   request  | start, busy            | req_op, rank, block x/y/z, number
//   result   | rsp_strobe             | owner, valid, local count, index, xyz, flag
//   csr      | csr_valid, csr_ready   | csr_index, csr_wdata
//
// One transaction is accepted every cycle while busy is low, that is outside reset.
// The latency is set by four rows of divider cells, one cell per quotient bit.
// Reset is synchronous; busy and csr_ready reflect reset only.
// The receiver cannot stall, so the strobe is never held back.
// ----------------------------------------------------------------------------
module block_to_process_mapper import btpm_pkg::*; #(
   parameter int DIM_BITS  = 10,
   parameter int RANK_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [OP_W-1:0]               req_op,
   input  logic [RANK_IN_W-1:0]          req_process_rank,
   input  logic signed [COORD_IN_W-1:0]  req_block_x,
   input  logic signed [COORD_IN_W-1:0]  req_block_y,
   input  logic signed [COORD_IN_W-1:0]  req_block_z,
   input  logic [BNUM_W-1:0]             req_block_number,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_wdata,
   output logic                          rsp_strobe,
   output logic [OWNER_W-1:0]            rsp_owner_process,
   output logic                          rsp_result_valid,
   output logic [LOCAL_W-1:0]            rsp_local_blocks,
   output logic signed [LIN_W-1:0]       rsp_linear_index,
   output logic [COORD_OUT_W-1:0]        rsp_coord_x,
   output logic [COORD_OUT_W-1:0]        rsp_coord_y,
   output logic [COORD_OUT_W-1:0]        rsp_coord_z,
   output logic                          rsp_is_local_flag
);

   localparam int BW   = DIM_BITS + 1;
   localparam int PW   = RANK_BITS;
   localparam int OSW  = PW + 1;
   localparam int BXYW = 2 * DIM_BITS + 1;
   localparam int NW   = 3 * DIM_BITS + 1;
   localparam int QW   = PW + NW;
   localparam int GW   = ((NW > BNUM_W) ? NW : BNUM_W) + 1;
   localparam int WD   = (GW > QW) ? GW : QW;
   localparam int BYZW = BW + 17;
   localparam int T2W  = BW + 18;
   localparam int IB4W = (2 * BW + 20 > LIN_W) ? 2 * BW + 20 : LIN_W;
   localparam int DW   = ((IB4W > NW + 1) ? IB4W : NW + 1) + 1;
   localparam int LATENCY = 12 + COORD_IN_W + QW + GW + WD;

   typedef struct packed {
      logic [OP_W-1:0]              op;
      logic                         rank_ok;
      logic [BNUM_W-1:0]            bnum;
      logic signed [COORD_IN_W-1:0] x;
      logic signed [COORD_IN_W-1:0] y;
      logic signed [COORD_IN_W-1:0] z;
      logic [BW-1:0]                bx;
      logic [BW-1:0]                by;
      logic [BW-1:0]                bz;
      logic [PW-1:0]                first;
      logic [PW-1:0]                p;
      logic [PW-1:0]                p0;
      logic [BXYW-1:0]              bxby;
      logic [NW-1:0]                n;
      logic signed [BYZW-1:0]       byz;
      logic signed [T2W-1:0]        t2;
      logic signed [IB4W-1:0]       acc;
      logic [QW-1:0]                num_s;
      logic [QW-1:0]                num_e;
      logic [BW-1:0]                wx;
      logic [BW-1:0]                wy;
      logic [BW-1:0]                wz;
      logic [NW-1:0]                ib0;
      logic [NW-1:0]                start;
      logic [NW-1:0]                count;
      logic [GW-1:0]                g;
      logic [BW-1:0]                r1;
      logic [QW-1:0]                odiv;
   } item_type;

   localparam int PLW = $bits(item_type);

   logic [DIMREG_W-1:0]   bx_ff, by_ff, bz_ff;
   logic [CSR_DATA_W-1:0] first_ff, total_ff;
   logic                  accept;

   function automatic logic [BW-1:0] dim_eff(input logic [DIMREG_W-1:0] v);
      logic [BW-1:0] r;
      if (v == '0) begin
         r = BW'(1);
      end else if (32'(v) > (32'd1 << DIM_BITS)) begin
         r = BW'(32'd1 << DIM_BITS);
      end else begin
         r = BW'(v);
      end
      return r;
   endfunction

   assign busy      = reset;
   assign csr_ready = !reset;
   assign accept    = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         bx_ff    <= DIMREG_W'(1);
         by_ff    <= DIMREG_W'(1);
         bz_ff    <= DIMREG_W'(1);
         first_ff <= '0;
         total_ff <= CSR_DATA_W'(1);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_BLOCKS_X:      bx_ff    <= csr_wdata[DIMREG_W-1:0];
            CSR_BLOCKS_Y:      by_ff    <= csr_wdata[DIMREG_W-1:0];
            CSR_BLOCKS_Z:      bz_ff    <= csr_wdata[DIMREG_W-1:0];
            CSR_FIRST_PROCESS: first_ff <= csr_wdata;
            CSR_PROCESS_TOTAL: total_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Front stages: capture, products for the unwrapped index and the share bounds.
   item_type s0_ff, s0_in, s1_ff, s1_in, s2_ff, s2_in, s3_ff, s3_in, s4_ff, s4_in;
   logic     s0_v_ff, s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff;
   logic [PW-1:0] rank_r, first_r, p_r;

   always_comb begin
      rank_r  = PW'(req_process_rank);
      first_r = PW'(first_ff);
      p_r     = PW'(total_ff);
      if (p_r == '0) begin
         p_r = PW'(1);
      end
      s0_in         = '0;
      s0_in.op      = req_op;
      s0_in.bnum    = req_block_number;
      s0_in.x       = req_block_x;
      s0_in.y       = req_block_y;
      s0_in.z       = req_block_z;
      s0_in.bx      = dim_eff(bx_ff);
      s0_in.by      = dim_eff(by_ff);
      s0_in.bz      = dim_eff(bz_ff);
      s0_in.first   = first_r;
      s0_in.p       = p_r;
      s0_in.rank_ok = (rank_r >= first_r) && ((rank_r - first_r) < p_r);
      s0_in.p0      = s0_in.rank_ok ? rank_r - first_r : '0;
   end

   always_comb begin
      s1_in      = s0_ff;
      s1_in.bxby = BXYW'(s0_ff.bx) * BXYW'(s0_ff.by);
      s1_in.byz  = BYZW'($signed({1'b0, s0_ff.by})) * BYZW'(s0_ff.z);
   end

   always_comb begin
      s2_in    = s1_ff;
      s2_in.n  = NW'(s1_ff.bxby) * NW'(s1_ff.bz);
      s2_in.t2 = T2W'(s1_ff.y) + T2W'(s1_ff.byz);
   end

   always_comb begin
      s3_in       = s2_ff;
      s3_in.acc   = IB4W'($signed({1'b0, s2_ff.bx})) * IB4W'(s2_ff.t2);
      s3_in.num_s = QW'(s2_ff.p0) * QW'(s2_ff.n);
      s3_in.num_e = (QW'(s2_ff.p0) + QW'(1)) * QW'(s2_ff.n);
   end

   always_comb begin
      s4_in     = s3_ff;
      s4_in.acc = IB4W'(s3_ff.x) + s3_ff.acc;
   end

   // Periodic wrap of the coordinates.
   logic [2:0][COORD_IN_W-1:0] a_num;
   logic [2:0][BW-1:0]         a_div, a_rem;
   logic                       a_v;
   logic [PLW-1:0]             a_pay;

   always_comb begin
      a_num[0] = s4_ff.x[COORD_IN_W-1] ? COORD_IN_W'(-s4_ff.x) : COORD_IN_W'(s4_ff.x);
      a_num[1] = s4_ff.y[COORD_IN_W-1] ? COORD_IN_W'(-s4_ff.y) : COORD_IN_W'(s4_ff.y);
      a_num[2] = s4_ff.z[COORD_IN_W-1] ? COORD_IN_W'(-s4_ff.z) : COORD_IN_W'(s4_ff.z);
      a_div[0] = s4_ff.bx;
      a_div[1] = s4_ff.by;
      a_div[2] = s4_ff.bz;
   end

   btpm_div_chain #(.LANES(3), .W(COORD_IN_W), .DV(BW), .PLW(PLW)) u_wrap (
      .clock    (clock),
      .reset    (reset),
      .in_valid (s4_v_ff),
      .in_pay   (s4_ff),
      .in_num   (a_num),
      .in_div   (a_div),
      .out_valid(a_v),
      .out_pay  (a_pay),
      .out_quo  (),
      .out_rem  (a_rem)
   );

   item_type s5_ff, s5_in, s6_ff, s6_in, s7_ff, s7_in, s8_ff, s8_in, s9_ff, s9_in;
   logic     s5_v_ff, s6_v_ff, s7_v_ff, s8_v_ff, s9_v_ff;

   always_comb begin
      s5_in    = item_type'(a_pay);
      s5_in.wx = (s5_in.x[COORD_IN_W-1] && a_rem[0] != '0) ? s5_in.bx - a_rem[0] : a_rem[0];
      s5_in.wy = (s5_in.y[COORD_IN_W-1] && a_rem[1] != '0) ? s5_in.by - a_rem[1] : a_rem[1];
      s5_in.wz = (s5_in.z[COORD_IN_W-1] && a_rem[2] != '0) ? s5_in.bz - a_rem[2] : a_rem[2];
   end

   always_comb begin
      s6_in     = s5_ff;
      s6_in.ib0 = NW'(s5_ff.by) * NW'(s5_ff.wz);
   end

   always_comb begin
      s7_in     = s6_ff;
      s7_in.ib0 = NW'(s6_ff.wy) + s6_ff.ib0;
   end

   always_comb begin
      s8_in     = s7_ff;
      s8_in.ib0 = NW'(s7_ff.bx) * s7_ff.ib0;
   end

   always_comb begin
      s9_in     = s8_ff;
      s9_in.ib0 = NW'(s8_ff.wx) + s8_ff.ib0;
   end

   // Share bounds of the queried process.
   logic [1:0][QW-1:0] b_num, b_quo;
   logic [1:0][PW-1:0] b_div;
   logic               b_v;
   logic [PLW-1:0]     b_pay;

   assign b_num[0] = s9_ff.num_s;
   assign b_num[1] = s9_ff.num_e;
   assign b_div[0] = s9_ff.p;
   assign b_div[1] = s9_ff.p;

   btpm_div_chain #(.LANES(2), .W(QW), .DV(PW), .PLW(PLW)) u_share (
      .clock    (clock),
      .reset    (reset),
      .in_valid (s9_v_ff),
      .in_pay   (s9_ff),
      .in_num   (b_num),
      .in_div   (b_div),
      .out_valid(b_v),
      .out_pay  (b_pay),
      .out_quo  (b_quo),
      .out_rem  ()
   );

   item_type s10_ff, s10_in;
   logic     s10_v_ff;

   always_comb begin
      s10_in       = item_type'(b_pay);
      s10_in.start = NW'(b_quo[0]);
      s10_in.count = NW'(b_quo[1]) - NW'(b_quo[0]);
      s10_in.g     = GW'(s10_in.bnum) + GW'(b_quo[0]);
      if (s10_in.op == OP_OWNER_COORD) begin
         s10_in.odiv = QW'(s10_in.p) * QW'(s10_in.ib0);
      end else begin
         s10_in.odiv = QW'(s10_in.p) * QW'(s10_in.bnum);
      end
   end

   // Decomposition of the global index, first along x.
   logic [0:0][GW-1:0] c_num, c_quo;
   logic [0:0][BW-1:0] c_div, c_rem;
   logic               c_v;
   logic [PLW-1:0]     c_pay;

   assign c_num[0] = s10_ff.g;
   assign c_div[0] = s10_ff.bx;

   btpm_div_chain #(.LANES(1), .W(GW), .DV(BW), .PLW(PLW)) u_along_x (
      .clock    (clock),
      .reset    (reset),
      .in_valid (s10_v_ff),
      .in_pay   (s10_ff),
      .in_num   (c_num),
      .in_div   (c_div),
      .out_valid(c_v),
      .out_pay  (c_pay),
      .out_quo  (c_quo),
      .out_rem  (c_rem)
   );

   // Decomposition along y and the owner quotient side by side.
   item_type           d_pay_in;
   logic [1:0][WD-1:0] d_num, d_quo;
   logic [1:0][NW-1:0] d_div, d_rem;
   logic               d_v;
   logic [PLW-1:0]     d_pay;

   always_comb begin
      d_pay_in    = item_type'(c_pay);
      d_pay_in.r1 = c_rem[0];
      d_num[0]    = WD'(c_quo[0]);
      d_num[1]    = WD'(d_pay_in.odiv);
      d_div[0]    = NW'(d_pay_in.by);
      d_div[1]    = d_pay_in.n;
   end

   btpm_div_chain #(.LANES(2), .W(WD), .DV(NW), .PLW(PLW)) u_owner (
      .clock    (clock),
      .reset    (reset),
      .in_valid (c_v),
      .in_pay   (d_pay_in),
      .in_num   (d_num),
      .in_div   (d_div),
      .out_valid(d_v),
      .out_pay  (d_pay),
      .out_quo  (d_quo),
      .out_rem  (d_rem)
   );

   // Result assembly.
   item_type                f;
   logic [OSW-1:0]          owner_sum;
   logic signed [DW-1:0]    share_ofs;
   logic [OWNER_W-1:0]      owner_in, owner_ff;
   logic                    valid_in, valid_ff;
   logic [LOCAL_W-1:0]      local_in, local_ff;
   logic [LIN_W-1:0]        lin_in, lin_ff;
   logic [COORD_OUT_W-1:0]  cx_in, cx_ff, cy_in, cy_ff, cz_in, cz_ff;
   logic                    isl_in, isl_ff;
   logic                    strobe_ff;

   always_comb begin
      f         = item_type'(d_pay);
      owner_sum = OSW'(f.first) + OSW'(d_quo[1]);
      share_ofs = DW'(f.acc) - DW'($signed({1'b0, f.start}));
      owner_in  = '0;
      valid_in  = 1'b0;
      local_in  = '0;
      lin_in    = '0;
      cx_in     = '0;
      cy_in     = '0;
      cz_in     = '0;
      isl_in    = 1'b0;
      unique case (f.op)
         OP_OWNER_COORD: begin
            owner_in = OWNER_W'(owner_sum);
            valid_in = 1'b1;
            lin_in   = LIN_W'(f.ib0);
            cx_in    = COORD_OUT_W'(f.wx);
            cy_in    = COORD_OUT_W'(f.wy);
            cz_in    = COORD_OUT_W'(f.wz);
         end
         OP_OWNER_INDEX: begin
            if (GW'(f.bnum) < GW'(f.n)) begin
               owner_in = OWNER_W'(owner_sum);
               valid_in = 1'b1;
            end
         end
         OP_LOCAL_COUNT: begin
            if (f.rank_ok) begin
               local_in = LOCAL_W'(f.count);
               valid_in = 1'b1;
            end
         end
         OP_LOCAL_TO_GLOBAL: begin
            if (f.rank_ok) begin
               lin_in   = LIN_W'(f.g);
               cx_in    = COORD_OUT_W'(f.r1);
               cy_in    = COORD_OUT_W'(d_rem[0]);
               cz_in    = COORD_OUT_W'(d_quo[0]);
               valid_in = GW'(f.bnum) < GW'(f.count);
            end
         end
         OP_IS_LOCAL: begin
            lin_in = LIN_W'(f.acc);
            if (f.rank_ok) begin
               valid_in = 1'b1;
               isl_in   = !share_ofs[DW-1] &&
                          (share_ofs < DW'($signed({1'b0, f.count})));
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff   <= 1'b0;
         s1_v_ff   <= 1'b0;
         s2_v_ff   <= 1'b0;
         s3_v_ff   <= 1'b0;
         s4_v_ff   <= 1'b0;
         s5_v_ff   <= 1'b0;
         s6_v_ff   <= 1'b0;
         s7_v_ff   <= 1'b0;
         s8_v_ff   <= 1'b0;
         s9_v_ff   <= 1'b0;
         s10_v_ff  <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         s0_v_ff   <= accept;
         s1_v_ff   <= s0_v_ff;
         s2_v_ff   <= s1_v_ff;
         s3_v_ff   <= s2_v_ff;
         s4_v_ff   <= s3_v_ff;
         s5_v_ff   <= a_v;
         s6_v_ff   <= s5_v_ff;
         s7_v_ff   <= s6_v_ff;
         s8_v_ff   <= s7_v_ff;
         s9_v_ff   <= s8_v_ff;
         s10_v_ff  <= b_v;
         strobe_ff <= d_v;
      end
      s0_ff    <= s0_in;
      s1_ff    <= s1_in;
      s2_ff    <= s2_in;
      s3_ff    <= s3_in;
      s4_ff    <= s4_in;
      s5_ff    <= s5_in;
      s6_ff    <= s6_in;
      s7_ff    <= s7_in;
      s8_ff    <= s8_in;
      s9_ff    <= s9_in;
      s10_ff   <= s10_in;
      owner_ff <= owner_in;
      valid_ff <= valid_in;
      local_ff <= local_in;
      lin_ff   <= lin_in;
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      cz_ff    <= cz_in;
      isl_ff   <= isl_in;
   end

   assign rsp_strobe        = strobe_ff;
   assign rsp_owner_process = owner_ff;
   assign rsp_result_valid  = valid_ff;
   assign rsp_local_blocks  = local_ff;
   assign rsp_linear_index  = $signed(lin_ff);
   assign rsp_coord_x       = cx_ff;
   assign rsp_coord_y       = cy_ff;
   assign rsp_coord_z       = cz_ff;
   assign rsp_is_local_flag = isl_ff;

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LATENCY rsp_strobe)
      else $error("accepted transaction produced no result");

   a_result_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, LATENCY))
      else $error("result without a matching transaction");

   a_local_flag_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_is_local_flag) |-> rsp_result_valid)
      else $error("local flag set on an invalid result");

endmodule
